### design/msx_pkg.sv
// ============================================================================
// msx_pkg
// Shared types and codes for the MIPS subset execute unit.
// ============================================================================
`default_nettype none

package msx_pkg;

    // Commands carried with each input word
    localparam logic [1:0] CMD_EXEC = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_BADADDR = 2'd2;
    localparam logic [1:0] ST_DIVZERO = 2'd3;

    // Primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2b;

    // Function codes under OP_SPECIAL
    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_DIV  = 6'h1a;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_SUB  = 6'h22;

    // Register select codes beyond the general file
    localparam logic [5:0] SEL_HI = 6'd32;
    localparam logic [5:0] SEL_LO = 6'd33;

    // Register reset values
    localparam logic [4:0]  RF_GP_IDX   = 5'd28;
    localparam logic [4:0]  RF_SP_IDX   = 5'd29;
    localparam logic [31:0] RF_GP_RESET = 32'h0000_1800;
    localparam logic [31:0] RF_SP_RESET = 32'h0000_3ffc;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MEM,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    // Register file write port
    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [31:0] data;
    } t_rf_wr;

    // Routing decided while decoding
    typedef struct packed {
        logic mem_rd;
        logic mul;
        logic div;
    } t_route;

    // One result word
    typedef struct packed {
        logic [31:0] read_value;
        logic [13:0] mem_byte_address;
        logic        mem_written;
        logic [31:0] written_value;
        logic [5:0]  dest_reg;
        logic        reg_written;
        logic [1:0]  status;
    } t_result;

    function automatic logic [31:0] rf_reset_value(input logic [4:0] idx);
        logic [31:0] v;
        v = '0;
        if (idx == RF_GP_IDX) v = RF_GP_RESET;
        if (idx == RF_SP_IDX) v = RF_SP_RESET;
        return v;
    endfunction

endpackage

`default_nettype wire

### design/mips_subset_execute_unit.sv
// ============================================================================
// mips_subset_execute_unit
// Executes a MIPS integer subset against a register file, HI/LO and a
// word data memory; also preloads memory words and reads registers.
// ============================================================================
// Usage:
//   Input stream s_axis: one word per command (execute, load memory word,
//   read register). Output stream m_axis: exactly one result word per input.
//   The unit works on one word at a time. o_s_axis_tready is high only while
//   idle. A word goes from accept through the execute and done states for ALU,
//   register moves, stores and reads; lw adds a data memory read state and
//   mult a registered product state; div waits on the 32-step divider.
//   The result sits in an output register; the unit returns to idle once the
//   result is loaded there, so a stalled receiver holds only the next result.
//   Reset (synchronous, active low) clears control, HI/LO and the register
//   file valid bits, so r28 = 0x1800, r29 = 0x3ffc, others zero. Data memory
//   is not cleared and needs no clearing pass; reading an unwritten word
//   returns undefined data.
// ============================================================================
`default_nettype none

module mips_subset_execute_unit #(
    parameter int MEM_WORDS = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // command[1:0], instruction[33:2], word_address[45:34],
    // load_value[77:46], reg_select[83:78], zero fill
    input  wire logic [87:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // status[1:0], reg_written[2], dest_reg[8:3], written_value[40:9],
    // mem_written[41], mem_byte_address[55:42], read_value[87:56]
    output logic [87:0]      o_m_axis_tdata
);
    import msx_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);

    t_state      r_state, n_state;
    logic [1:0]  r_cmd;
    logic [31:0] r_ins;
    logic [11:0] r_waddr;
    logic [31:0] r_lval;
    logic [5:0]  r_sel;
    t_result     r_res, n_res;
    t_result     r_out;
    logic        r_ovalid;
    logic [31:0] r_hi, r_lo;
    logic [63:0] r_prod;

    logic        accept;
    logic        out_free;
    logic [31:0] rf_a, rf_b;
    t_rf_wr      rf_wr;
    t_route      route;
    logic        dm_we, dm_re;
    logic [AW-1:0] dm_waddr, dm_raddr;
    logic [31:0] dm_wdata, dm_q;
    logic        div_start, div_done;
    logic [31:0] div_q, div_r;

    // instruction fields
    logic [5:0]  op, fn;
    logic [4:0]  rt, rd;
    logic [31:0] imm, ea;
    logic        ea_bad, lw_bad;

    assign op  = r_ins[31:26];
    assign rt  = r_ins[20:16];
    assign rd  = r_ins[15:11];
    assign fn  = r_ins[5:0];
    assign imm = {{16{r_ins[15]}}, r_ins[15:0]};
    assign ea  = rf_a + imm;
    assign ea_bad = (ea[1:0] != 2'b00) || ({2'b00, ea[31:2]} >= 32'(MEM_WORDS));
    assign lw_bad = ({20'd0, r_waddr} >= 32'(MEM_WORDS));

    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ovalid || i_m_axis_tready;

    // rs is instruction[25:21], rt is instruction[20:16]
    msx_regfile u_rf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_a_addr (i_s_axis_tdata[27:23]),
        .i_rd_b_addr ((i_s_axis_tdata[1:0] == CMD_READ) ? i_s_axis_tdata[82:78]
                                                        : i_s_axis_tdata[22:18]),
        .i_wr        (rf_wr),
        .o_rd_a      (rf_a),
        .o_rd_b      (rf_b)
    );

    msx_dmem #(.MEM_WORDS(MEM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_re    (dm_re),
        .i_raddr (dm_raddr),
        .o_rdata (dm_q)
    );

    msx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (rf_a),
        .i_divisor  (rf_b),
        .o_done     (div_done),
        .o_quo      (div_q),
        .o_rem      (div_r)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_EXEC;
            S_EXEC: begin
                if (route.mem_rd)   n_state = S_MEM;
                else if (route.mul) n_state = S_MUL;
                else if (route.div) n_state = S_DIV;
                else                n_state = S_DONE;
            end
            S_MEM:  n_state = S_DONE;
            S_MUL:  n_state = S_DONE;
            S_DIV:  if (div_done) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // decode and execute
    always_comb begin
        n_res     = r_res;
        route     = '0;
        rf_wr     = '0;
        dm_we     = 1'b0;
        dm_waddr  = ea[AW+1:2];
        dm_wdata  = rf_b;
        dm_re     = 1'b0;
        dm_raddr  = ea[AW+1:2];
        div_start = 1'b0;
        o_s_axis_tready = (r_state == S_IDLE);
        unique case (r_state)
            S_EXEC: begin
                n_res = '0;
                unique case (r_cmd)
                    CMD_EXEC: begin
                        if (op == OP_SPECIAL) begin
                            case (fn)
                                FN_ADD, FN_SUB, FN_MFHI, FN_MFLO: begin
                                    rf_wr.addr = rd;
                                    case (fn)
                                        FN_ADD:  rf_wr.data = rf_a + rf_b;
                                        FN_SUB:  rf_wr.data = rf_a - rf_b;
                                        FN_MFHI: rf_wr.data = r_hi;
                                        default: rf_wr.data = r_lo;
                                    endcase
                                    rf_wr.en = (rd != 5'd0);
                                end
                                FN_MULT: route.mul = 1'b1;
                                FN_DIV: begin
                                    if (rf_b == 32'd0) begin
                                        n_res.status = ST_DIVZERO;
                                    end else begin
                                        route.div = 1'b1;
                                        div_start = 1'b1;
                                    end
                                end
                                default: n_res.status = ST_UNKNOWN;
                            endcase
                        end else begin
                            case (op)
                                OP_ADDI, OP_ADDIU: begin
                                    rf_wr.addr = rt;
                                    rf_wr.data = ea;
                                    rf_wr.en   = (rt != 5'd0);
                                end
                                OP_LUI: begin
                                    rf_wr.addr = rt;
                                    rf_wr.data = {r_ins[15:0], 16'd0};
                                    rf_wr.en   = (rt != 5'd0);
                                end
                                OP_LW, OP_SW: begin
                                    n_res.mem_byte_address = ea[13:0];
                                    if (ea_bad) begin
                                        n_res.status = ST_BADADDR;
                                    end else if (op == OP_LW) begin
                                        dm_re        = 1'b1;
                                        route.mem_rd = 1'b1;
                                    end else begin
                                        dm_we             = 1'b1;
                                        n_res.mem_written = 1'b1;
                                    end
                                end
                                default: n_res.status = ST_UNKNOWN;
                            endcase
                        end
                        if (rf_wr.en) begin
                            n_res.reg_written   = 1'b1;
                            n_res.dest_reg      = {1'b0, rf_wr.addr};
                            n_res.written_value = rf_wr.data;
                        end
                    end
                    CMD_LOAD: begin
                        n_res.mem_byte_address = {r_waddr, 2'b00};
                        dm_waddr = AW'(r_waddr);
                        dm_wdata = r_lval;
                        if (lw_bad) begin
                            n_res.status = ST_BADADDR;
                        end else begin
                            dm_we             = 1'b1;
                            n_res.mem_written = 1'b1;
                        end
                    end
                    CMD_READ: begin
                        if (!r_sel[5])          n_res.read_value = rf_b;
                        else if (r_sel == SEL_HI) n_res.read_value = r_hi;
                        else if (r_sel == SEL_LO) n_res.read_value = r_lo;
                        else                    n_res.status     = ST_UNKNOWN;
                    end
                    default: n_res.status = ST_UNKNOWN;
                endcase
            end
            S_MEM: begin
                rf_wr.addr = rt;
                rf_wr.data = dm_q;
                rf_wr.en   = (rt != 5'd0);
                if (rf_wr.en) begin
                    n_res.reg_written   = 1'b1;
                    n_res.dest_reg      = {1'b0, rt};
                    n_res.written_value = dm_q;
                end
            end
            S_MUL: begin
                n_res.reg_written   = 1'b1;
                n_res.dest_reg      = SEL_LO;
                n_res.written_value = r_prod[31:0];
            end
            S_DIV: begin
                if (div_done) begin
                    n_res.reg_written   = 1'b1;
                    n_res.dest_reg      = SEL_LO;
                    n_res.written_value = div_q;
                end
            end
            default: ;
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_s_axis_tdata[1:0];
            r_ins   <= i_s_axis_tdata[33:2];
            r_waddr <= i_s_axis_tdata[45:34];
            r_lval  <= i_s_axis_tdata[77:46];
            r_sel   <= i_s_axis_tdata[83:78];
        end
        r_res <= n_res;
        if (r_state == S_EXEC) begin
            r_prod <= 64'($signed(rf_a) * $signed(rf_b));
        end
        if (r_state == S_DONE && out_free) begin
            r_out <= r_res;
        end
    end

    // control state, HI/LO
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_hi     <= '0;
            r_lo     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_MUL) begin
                r_hi <= r_prod[63:32];
                r_lo <= r_prod[31:0];
            end else if (r_state == S_DIV && div_done) begin
                r_hi <= div_r;
                r_lo <= div_q;
            end
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_out;

endmodule

`default_nettype wire

### design/msx_regfile.sv
// ============================================================================
// msx_regfile
// 32 x 32 general register file: two registered read ports, one write port,
// per-entry valid bits so unwritten entries read as their reset values.
// ============================================================================
`default_nettype none

module msx_regfile (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_rd_en,
    input  wire logic [4:0]          i_rd_a_addr,
    input  wire logic [4:0]          i_rd_b_addr,
    input  wire msx_pkg::t_rf_wr     i_wr,
    output logic [31:0]              o_rd_a,
    output logic [31:0]              o_rd_b
);
    import msx_pkg::*;

    logic [31:0] r_mem [32];
    logic [31:0] r_valid;
    logic [31:0] r_qa, r_qb;
    logic [4:0]  r_aa, r_ab;
    logic        r_va, r_vb;

    // storage and registered reads
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_qa <= r_mem[i_rd_a_addr];
            r_qb <= r_mem[i_rd_b_addr];
            r_aa <= i_rd_a_addr;
            r_ab <= i_rd_b_addr;
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_va <= r_valid[i_rd_a_addr];
                r_vb <= r_valid[i_rd_b_addr];
            end
        end
    end

    assign o_rd_a = r_va ? r_qa : rf_reset_value(r_aa);
    assign o_rd_b = r_vb ? r_qb : rf_reset_value(r_ab);

endmodule

`default_nettype wire

### design/msx_dmem.sv
// ============================================================================
// msx_dmem
// Word data memory, one write and one registered read port.
// ============================================================================
`default_nettype none

module msx_dmem #(
    parameter int MEM_WORDS = 4096,
    localparam int AW = $clog2(MEM_WORDS)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic [31:0]        o_rdata
);
    logic [31:0] r_mem [MEM_WORDS];
    logic [31:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

### design/msx_div.sv
// ============================================================================
// msx_div
// Signed 32-bit divider, restoring, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module msx_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quo,
    output logic [31:0]      o_rem
);
    logic [32:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_mb;
    logic        r_na, r_nq;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;

    // one shift-subtract step
    assign rem_sh  = {r_rem[31:0], r_quo[31]};
    assign rem_sub = rem_sh - {1'b0, r_mb};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
            r_mb  <= i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
            r_na  <= i_dividend[31];
            r_nq  <= i_dividend[31] ^ i_divisor[31];
        end else if (r_busy && r_cnt != '0) begin
            if (!rem_sub[32]) begin
                r_rem <= rem_sub;
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd32;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quo  = r_nq ? (32'd0 - r_quo) : r_quo;
    assign o_rem  = r_na ? (32'd0 - r_rem[31:0]) : r_rem[31:0];

endmodule

`default_nettype wire

### sim/mips_subset_execute_unit_tb.sv
// ============================================================================
// mips_subset_execute_unit_tb
// Self-checking bench for the MIPS subset execute unit. A shadow copy of the
// register file, HI/LO and data memory predicts every result word. Results
// are compared field by field, in order. Directed tests come first, then a
// long random run with random sender gaps and receiver stalls.
// ============================================================================
`default_nettype none

module mips_subset_execute_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msx_pkg::*;

    localparam int N_WORDS     = 4096;
    localparam int RANDOM_WORDS = 540;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // command[1:0], instruction[33:2], word_address[45:34],
    // load_value[77:46], reg_select[83:78], zero fill
    logic [87:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // status[1:0], reg_written[2], dest_reg[8:3], written_value[40:9],
    // mem_written[41], mem_byte_address[55:42], read_value[87:56]
    logic [87:0] o_m_axis_tdata;

    mips_subset_execute_unit #(.MEM_WORDS(N_WORDS)) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Shadow architectural state
    logic [31:0] gpr [32];
    logic [31:0] hi_q, lo_q;
    logic [31:0] dmem [N_WORDS];
    bit          dmem_known [N_WORDS];

    t_result pending_results[$];
    int      n_errors   = 0;
    int      n_words    = 0;
    int      n_results  = 0;
    int      n_divs     = 0;
    int      n_flagged  = 0;
    bit      idle_en    = 1'b1;
    int      stall_left = 0;

    // Clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Run limit
    initial begin
        #5_000_000;
        $display("mips_subset_execute_unit_tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shadow execution
    // ------------------------------------------------------------------------
    function automatic void write_gpr(inout t_result r, input logic [4:0] idx,
                                      input logic [31:0] v);
        if (idx == 5'd0) return;   // $zero drops the write
        gpr[idx]        = v;
        r.reg_written   = 1'b1;
        r.dest_reg      = {1'b0, idx};
        r.written_value = v;
    endfunction

    function automatic t_result shadow_execute(logic [1:0] cmd, logic [31:0] ins,
                                               logic [11:0] wa, logic [31:0] lv,
                                               logic [5:0] sel);
        t_result r;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd;
        logic [31:0] a, b, imm, addr, ma, mb, q, rem;
        logic signed [63:0] prod;
        r = '0;
        op  = ins[31:26];
        rs  = ins[25:21];
        rt  = ins[20:16];
        rd  = ins[15:11];
        fn  = ins[5:0];
        imm = {{16{ins[15]}}, ins[15:0]};
        a   = gpr[rs];
        b   = gpr[rt];
        case (cmd)
            CMD_EXEC: begin
                if (op == OP_SPECIAL) begin
                    case (fn)
                        FN_ADD:  write_gpr(r, rd, a + b);
                        FN_SUB:  write_gpr(r, rd, a - b);
                        FN_MFHI: write_gpr(r, rd, hi_q);
                        FN_MFLO: write_gpr(r, rd, lo_q);
                        FN_MULT: begin
                            prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                            hi_q = prod[63:32];
                            lo_q = prod[31:0];
                            r.reg_written = 1'b1; r.dest_reg = SEL_LO;
                            r.written_value = lo_q;
                        end
                        FN_DIV: begin
                            if (b == 32'd0) begin
                                r.status = ST_DIVZERO;
                            end else begin
                                ma  = a[31] ? -a : a;
                                mb  = b[31] ? -b : b;
                                q   = ma / mb;
                                rem = ma % mb;
                                if (a[31] != b[31]) q = -q;
                                if (a[31]) rem = -rem;
                                hi_q = rem;
                                lo_q = q;
                                r.reg_written = 1'b1; r.dest_reg = SEL_LO;
                                r.written_value = q;
                            end
                        end
                        default: r.status = ST_UNKNOWN;
                    endcase
                end else if (op == OP_ADDI || op == OP_ADDIU) begin
                    write_gpr(r, rt, a + imm);
                end else if (op == OP_LUI) begin
                    write_gpr(r, rt, {ins[15:0], 16'h0000});
                end else if (op == OP_LW || op == OP_SW) begin
                    addr = a + imm;
                    r.mem_byte_address = addr[13:0];
                    if (addr[1:0] != 2'b00 || addr[31:2] >= N_WORDS) begin
                        r.status = ST_BADADDR;
                    end else if (op == OP_LW) begin
                        write_gpr(r, rt, dmem[addr[31:2]]);
                    end else begin
                        dmem[addr[31:2]]       = b;
                        dmem_known[addr[31:2]] = 1'b1;
                        r.mem_written          = 1'b1;
                    end
                end else begin
                    r.status = ST_UNKNOWN;
                end
            end
            CMD_LOAD: begin
                r.mem_byte_address = {wa, 2'b00};
                dmem[wa]       = lv;
                dmem_known[wa] = 1'b1;
                r.mem_written  = 1'b1;
            end
            CMD_READ: begin
                if (sel < 6'd32)       r.read_value = gpr[sel[4:0]];
                else if (sel == SEL_HI) r.read_value = hi_q;
                else if (sel == SEL_LO) r.read_value = lo_q;
                else                    r.status = ST_UNKNOWN;
            end
            default: r.status = ST_UNKNOWN;
        endcase
        return r;
    endfunction

    // Encoders
    function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, 5'd0, fn};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs,
                                          logic [4:0] rt, logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // ------------------------------------------------------------------------
    // Sender: predict, optional gap, then hold the word until accepted
    // ------------------------------------------------------------------------
    task automatic send_word(logic [1:0] cmd, logic [31:0] ins, logic [11:0] wa,
                             logic [31:0] lv, logic [5:0] sel);
        t_result exp_r;
        exp_r = shadow_execute(cmd, ins, wa, lv, sel);
        pending_results.push_back(exp_r);
        n_words++;
        if (cmd == CMD_EXEC && ins[31:26] == OP_SPECIAL && ins[5:0] == FN_DIV) n_divs++;
        if (exp_r.status != ST_OK) n_flagged++;
        if (idle_en && $urandom_range(0, 6) == 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {4'b0, sel, lv, wa, ins, cmd};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic exec_word(logic [31:0] ins);
        send_word(CMD_EXEC, ins, 12'($urandom), $urandom, 6'($urandom));
    endtask

    task automatic drain;
        i_s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // Receiver back-pressure in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready = 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            i_m_axis_tready = 1'b0;
        end else begin
            i_m_axis_tready = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] exp_v,
                                        logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result act_r, exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            act_r = t_result'(o_m_axis_tdata);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, o_m_axis_tdata);
                n_errors++;
            end else begin
                exp_r = pending_results.pop_front();
                n_results++;
                check_field("status",           exp_r.status,           act_r.status);
                check_field("reg_written",      exp_r.reg_written,      act_r.reg_written);
                check_field("dest_reg",         exp_r.dest_reg,         act_r.dest_reg);
                check_field("written_value",    exp_r.written_value,    act_r.written_value);
                check_field("mem_written",      exp_r.mem_written,      act_r.mem_written);
                check_field("mem_byte_address", exp_r.mem_byte_address,
                            act_r.mem_byte_address);
                check_field("read_value",       exp_r.read_value,       act_r.read_value);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset values, HI/LO, bad selects, unknown command
    task automatic test_reset_and_reads;
        send_word(CMD_READ, $urandom, 12'($urandom), $urandom, 6'd0);
        send_word(CMD_READ, $urandom, 12'($urandom), $urandom, {1'b0, RF_GP_IDX});
        send_word(CMD_READ, $urandom, 12'($urandom), $urandom, {1'b0, RF_SP_IDX});
        send_word(CMD_READ, $urandom, 12'($urandom), $urandom, SEL_HI);
        send_word(CMD_READ, $urandom, 12'($urandom), $urandom, SEL_LO);
        send_word(CMD_READ, $urandom, 12'($urandom), $urandom, 6'd34);
        send_word(CMD_READ, $urandom, 12'($urandom), $urandom, 6'd63);
        send_word(2'd3, $urandom, 12'($urandom), $urandom, 6'($urandom));
    endtask

    // ALU ops, wraparound, $zero writes, unknown codes
    task automatic test_alu;
        exec_word(enc_i(OP_LUI, 5'd0, 5'd1, 16'h8000));     // r1 = 0x80000000
        exec_word(enc_i(OP_ADDI, 5'd0, 5'd2, 16'hffff));    // r2 = -1
        exec_word(enc_i(OP_ADDIU, 5'd2, 5'd3, 16'h7fff));
        exec_word(enc_r(5'd1, 5'd2, 5'd4, FN_ADD));         // wraps
        exec_word(enc_r(5'd1, 5'd3, 5'd5, FN_SUB));
        exec_word(enc_r(5'd1, 5'd2, 5'd0, FN_ADD));         // write to $zero
        exec_word(enc_i(OP_LUI, 5'd0, 5'd0, 16'hffff));
        exec_word(enc_r(5'd1, 5'd2, 5'd4, 6'h21));          // unknown funct
        exec_word(enc_i(6'h3f, 5'd1, 5'd2, 16'h1234));      // unknown opcode
    endtask

    // mult/div, signed overflow, divide by zero
    task automatic test_muldiv;
        exec_word(enc_r(5'd1, 5'd1, 5'd0, FN_MULT));
        exec_word(enc_r(5'd0, 5'd0, 5'd6, FN_MFHI));
        exec_word(enc_r(5'd1, 5'd2, 5'd0, FN_DIV));         // most negative / -1
        exec_word(enc_r(5'd1, 5'd0, 5'd0, FN_DIV));         // divide by zero
        exec_word(enc_r(5'd0, 5'd0, 5'd7, FN_MFLO));
    endtask

    // Memory preload, lw/sw, bad addresses
    task automatic test_memory;
        send_word(CMD_LOAD, $urandom, 12'd0, 32'hdead_beef, 6'($urandom));
        send_word(CMD_LOAD, $urandom, 12'd4095, 32'hffff_ffff, 6'($urandom));
        exec_word(enc_i(OP_LW, 5'd0, 5'd8, 16'h0000));
        exec_word(enc_i(OP_SW, 5'd29, 5'd1, 16'h0000));     // top word
        exec_word(enc_i(OP_LW, 5'd29, 5'd9, 16'h0000));
        exec_word(enc_i(OP_LW, 5'd0, 5'd9, 16'h0002));      // misaligned
        exec_word(enc_i(OP_SW, 5'd0, 5'd9, 16'h4000));      // past the end
        exec_word(enc_i(OP_SW, 5'd28, 5'd9, 16'h8000));     // negative wrap
    endtask

    // Random addresses: mostly valid word addresses reached from any base
    function automatic logic [31:0] rand_mem_ins(logic [5:0] op);
        logic [4:0]  rs;
        logic [31:0] target, diff;
        rs = 5'($urandom);
        if ($urandom_range(0, 99) < 15) return enc_i(op, rs, 5'($urandom), 16'($urandom));
        target = $urandom_range(0, N_WORDS - 1) << 2;
        diff   = target - gpr[rs];
        if ($signed(diff) > 32767 || $signed(diff) < -32768) begin
            rs   = 5'd0;
            diff = target;
        end
        return enc_i(op, rs, 5'($urandom), diff[15:0]);
    endfunction

    task automatic test_random(int count);
        logic [31:0] ins, addr;
        logic [5:0]  fn;
        int          pick;
        for (int i = 0; i < count; i++) begin
            if (i == count - 100) idle_en = 1'b0;   // final stretch at full rate
            if (i == count / 2) drain;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_word(CMD_LOAD, $urandom, 12'($urandom), $urandom, 6'($urandom));
            end else if (pick < 16) begin
                send_word(CMD_READ, $urandom, 12'($urandom), $urandom, 6'($urandom));
            end else if (pick < 18) begin
                send_word(2'd3, $urandom, 12'($urandom), $urandom, 6'($urandom));
            end else begin
                case ($urandom_range(0, 11))
                    0, 1: ins = rand_mem_ins(OP_LW);
                    2, 3: ins = rand_mem_ins(OP_SW);
                    4:  ins = {6'($urandom_range(0, 1) ? OP_ADDI : OP_ADDIU), 26'($urandom)};
                    5:  ins = {OP_LUI, 26'($urandom)};
                    6:  ins = {$urandom_range(0, 1) ? 6'($urandom) : 6'h3f, 26'($urandom)};
                    default: begin
                        case ($urandom_range(0, 6))
                            0: fn = FN_ADD;  1: fn = FN_SUB;  2: fn = FN_MULT;
                            3: fn = FN_DIV;  4: fn = FN_MFHI; 5: fn = FN_MFLO;
                            default: fn = 6'($urandom);
                        endcase
                        ins = {OP_SPECIAL, 20'($urandom), fn};
                    end
                endcase
                // Never read a word that was never written: preload it first
                if (ins[31:26] == OP_LW) begin
                    addr = gpr[ins[25:21]] + {{16{ins[15]}}, ins[15:0]};
                    if (addr[1:0] == 2'b00 && addr[31:2] < N_WORDS
                            && !dmem_known[addr[31:2]])
                        send_word(CMD_LOAD, $urandom, addr[13:2], $urandom,
                                  6'($urandom));
                end
                exec_word(ins);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int k = 0; k < 32; k++) gpr[k] = rf_reset_value(5'(k));
        hi_q = '0;
        lo_q = '0;
        for (int k = 0; k < N_WORDS; k++) begin
            dmem[k] = '0;
            dmem_known[k] = 1'b0;
        end
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_and_reads();
        test_alu();
        test_muldiv();
        test_memory();
        drain();
        test_random(RANDOM_WORDS);

        i_s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);

        $display("Sent %0d words (%0d divides, %0d flagged), checked %0d results.",
                 n_words, n_divs, n_flagged, n_results);
        $display("Covered ALU, mult/div, memory, register reads and error codes.");
        if (n_errors == 0 && pending_results.size() == 0)
            $display("mips_subset_execute_unit_tb: done, clean");
        else
            $display("mips_subset_execute_unit_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

### mips_subset_execute_unit.f
design/msx_pkg.sv
design/msx_regfile.sv
design/msx_dmem.sv
design/msx_div.sv
design/mips_subset_execute_unit.sv
sim/mips_subset_execute_unit_tb.sv
